/* rtl/rmid_pkg.sv */
// Package for the running median block: shared types, codes and fixed field widths.
package rmid_pkg;

  localparam int HELD_W   = 11;
  localparam int STATUS_W = 2;

  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_APPLIED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  // Per-cell comparison result, captured when an item is accepted.
  typedef struct packed {
    logic occ;     // cell lies inside the occupied window
    logic lt;      // occupied and value below the key
    logic gt;      // occupied and value above the key
    logic eq;      // occupied and value equal to the key
    logic at_lm1;  // cell sits just left of the window
    logic at_hp1;  // cell sits just right of the window
  } rmid_flags_t;

  // Shift command broadcast to every cell during the shift cycle.
  typedef struct packed {
    logic ins_l;   // insert, lower part moves one cell left
    logic ins_r;   // insert, upper part moves one cell right
    logic del_l;   // delete, upper part moves one cell left
    logic del_r;   // delete, lower part moves one cell right
  } rmid_cmd_t;

endpackage

/* rtl/rmid_if.sv */
// Valid/ready channel interfaces for the running median block.
interface rmid_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, mode, value, input ready);
  modport sink   (input valid, mode, value, output ready);
endinterface

interface rmid_out_if #(
  parameter int VALUE_BITS = 32
);
  import rmid_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_BITS:0] median_doubled;
  logic                       empty_res;
  logic [HELD_W-1:0]          held_count;
  logic [STATUS_W-1:0]        status;

  modport source (output valid, median_doubled, empty_res, held_count, status, input ready);
  modport sink   (input valid, median_doubled, empty_res, held_count, status, output ready);
endinterface

/* rtl/rmid_cell.sv */
// One cell of the sorted value chain: holds one value and shifts it to a neighbour.
module rmid_cell #(
  parameter int VB       = 32,
  parameter int BW       = 11,
  parameter int CELL_IDX = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  capture,
  input  logic signed [VB-1:0]  key,
  input  rmid_pkg::rmid_cmd_t   cmd,
  input  logic signed [VB-1:0]  ins_val,
  input  logic [BW-1:0]         lo,
  input  logic [BW-1:0]         hi,
  input  logic signed [VB-1:0]  left_val,
  input  rmid_pkg::rmid_flags_t left_flags,
  input  logic signed [VB-1:0]  right_val,
  input  rmid_pkg::rmid_flags_t right_flags,
  output logic signed [VB-1:0]  val,
  output rmid_pkg::rmid_flags_t flags,
  output logic                  hit
);
  import rmid_pkg::*;

  localparam logic [BW-1:0] IDX_B = BW'(CELL_IDX);

  logic signed [VB-1:0] val_r, val_nxt;
  rmid_flags_t          flags_r, flags_nxt;
  logic                 occ;
  logic                 le_self, le_right, ge_self, ge_left;

  // Compare against the incoming key; the result is held for the shift cycle.
  always_comb begin
    occ              = (IDX_B >= lo) && (IDX_B <= hi);
    flags_nxt.occ    = occ;
    flags_nxt.lt     = occ && (val_r < key);
    flags_nxt.gt     = occ && (val_r > key);
    flags_nxt.eq     = occ && (val_r == key);
    flags_nxt.at_lm1 = ((IDX_B + BW'(1)) == lo);
    flags_nxt.at_hp1 = (IDX_B == (hi + BW'(1)));
  end

  always_comb begin
    le_self  = flags_r.occ && !flags_r.gt;
    le_right = right_flags.occ && !right_flags.gt;
    ge_self  = flags_r.occ && !flags_r.lt;
    ge_left  = left_flags.occ && !left_flags.lt;
    // The first cell at or above the key marks a removal target when it matches.
    hit      = flags_r.eq && !ge_left;

    val_nxt = val_r;
    if (cmd.ins_l) begin
      if (le_right) begin
        val_nxt = right_val;
      end else if (le_self || flags_r.at_lm1) begin
        val_nxt = ins_val;
      end
    end else if (cmd.ins_r) begin
      if (left_flags.gt) begin
        val_nxt = left_val;
      end else if (flags_r.gt || flags_r.at_hp1) begin
        val_nxt = ins_val;
      end
    end else if (cmd.del_l) begin
      if (ge_self) begin
        val_nxt = right_val;
      end
    end else if (cmd.del_r) begin
      if (left_flags.lt) begin
        val_nxt = left_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (capture) begin
      flags_r <= flags_nxt;
    end
  end

  assign val   = val_r;
  assign flags = flags_r;

endmodule

/* rtl/running_median_insert_delete.sv */
// Top level of the running median block: cell chain, sequencer and result register.
//
//   Channel   Direction  Payload                                           Handshake
//   in_ch     sink       mode, value                                       valid / ready
//   out_ch    source     median_doubled, empty_res, held_count, status     valid / ready
//
// When results are drained promptly, the cells compare at the acceptance edge, shift in the
// shift state, and the result register is loaded from the result state at the same edge that
// may accept the following item. Reset is synchronous and active low; it empties the store
// at once, with no clearing pass. A stalled result holds the block in its result state; no
// further item is taken until the result register can be loaded.
module running_median_insert_delete #(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  rmid_in_if.sink    in_ch,
  rmid_out_if.source out_ch
);
  import rmid_pkg::*;

  // The sorted values live in a window of the chain that is kept centred: the lower middle
  // element always sits in cell MID and the upper middle element, for an even count, in
  // cell MID + 1. An insertion or removal therefore shifts only one side of the window.
  localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int BW  = IW + 1;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int MID = (CAPACITY - 1) / 2;
  localparam logic [CW-1:0] CAP_C   = CW'(CAPACITY);
  localparam logic [BW-1:0] MID_B   = BW'(MID);
  localparam logic [BW-1:0] MID_B1  = BW'(MID + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SHIFT = 3'b010,
    S_MED   = 3'b100
  } state_t;

  state_t                       state_r, state_nxt;
  logic signed [VALUE_BITS-1:0] v_r;
  logic                         mode_r;
  logic                         full_r;
  logic [BW-1:0]                lo_r, lo_nxt;
  logic [BW-1:0]                hi_r, hi_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [STATUS_W-1:0]          status_r, status_nxt;

  logic signed [VALUE_BITS:0]   out_med_r;
  logic                         out_empty_r;
  logic [HELD_W-1:0]            out_held_r;
  logic [STATUS_W-1:0]          out_status_r;
  logic                         out_valid_r;

  logic                         in_accept;
  logic                         out_free;
  logic                         load_out;
  logic                         found;
  logic                         even;
  logic                         ins_ok, del_ok;
  rmid_cmd_t                    cmd;

  logic signed [VALUE_BITS-1:0] vals_ext  [CAPACITY+2];
  rmid_flags_t                  flags_ext [CAPACITY+2];
  logic [CAPACITY-1:0]          hit_vec;

  logic signed [VALUE_BITS-1:0] val_mid, val_mid1;
  logic signed [VALUE_BITS:0]   med_nxt;
  logic [HELD_W+CW-1:0]         held_ext;

  // Chain ends present empty neighbours.
  assign vals_ext[0]           = '0;
  assign vals_ext[CAPACITY+1]  = '0;
  assign flags_ext[0]          = '0;
  assign flags_ext[CAPACITY+1] = '0;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      rmid_cell #(
        .VB       (VALUE_BITS),
        .BW       (BW),
        .CELL_IDX (g)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .capture     (in_accept),
        .key         (in_ch.value),
        .cmd         (cmd),
        .ins_val     (v_r),
        .lo          (lo_r),
        .hi          (hi_r),
        .left_val    (vals_ext[g]),
        .left_flags  (flags_ext[g]),
        .right_val   (vals_ext[g+2]),
        .right_flags (flags_ext[g+2]),
        .val         (vals_ext[g+1]),
        .flags       (flags_ext[g+1]),
        .hit         (hit_vec[g])
      );
    end
  endgenerate

  // Handshake. The result register frees up when it is empty or being taken this cycle.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) || ((state_r == S_MED) && out_free);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign load_out    = (state_r == S_MED) && out_free;

  // Shift command. The parity of the count before the change decides which side moves,
  // so that the middle of the window stays on the fixed cells.
  always_comb begin
    found     = |hit_vec;
    even      = !count_r[0];
    ins_ok    = (state_r == S_SHIFT) && (mode_r == MODE_ADD) && !full_r;
    del_ok    = (state_r == S_SHIFT) && (mode_r == MODE_REMOVE) && found;
    cmd.ins_l = ins_ok && even;
    cmd.ins_r = ins_ok && !even;
    cmd.del_l = del_ok && even;
    cmd.del_r = del_ok && !even;
  end

  always_comb begin
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    if (state_r == S_SHIFT) begin
      if (cmd.ins_l) begin
        lo_nxt = lo_r - BW'(1);
      end
      if (cmd.ins_r) begin
        hi_nxt = hi_r + BW'(1);
      end
      if (cmd.del_l) begin
        hi_nxt = hi_r - BW'(1);
      end
      if (cmd.del_r) begin
        lo_nxt = lo_r + BW'(1);
      end
      if (ins_ok) begin
        count_nxt = count_r + CW'(1);
      end else if (del_ok) begin
        count_nxt = count_r - CW'(1);
      end
      if (mode_r == MODE_ADD) begin
        status_nxt = full_r ? ST_FULL : ST_APPLIED;
      end else begin
        status_nxt = found ? ST_APPLIED : ST_NOT_FOUND;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        state_nxt = S_MED;
      end
      S_MED: begin
        if (in_accept) begin
          state_nxt = S_SHIFT;
        end else if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Median from the fixed middle cells: twice the middle value for an odd count, the sum of
  // the two middle values for an even count, and zero when the store is empty.
  always_comb begin
    val_mid  = vals_ext[MID+1];
    val_mid1 = vals_ext[MID+2];
    if (count_r == '0) begin
      med_nxt = '0;
    end else if (count_r[0]) begin
      med_nxt = {val_mid, 1'b0};
    end else begin
      med_nxt = {val_mid[VALUE_BITS-1], val_mid} + {val_mid1[VALUE_BITS-1], val_mid1};
    end
    held_ext = {{HELD_W{1'b0}}, count_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lo_r        <= MID_B1;
      hi_r        <= MID_B;
      count_r     <= '0;
      status_r    <= ST_APPLIED;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_ADD;
      full_r      <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_accept) begin
        mode_r <= in_ch.mode;
        full_r <= (count_r == CAP_C);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      v_r <= in_ch.value;
    end
    if (load_out) begin
      out_med_r    <= med_nxt;
      out_empty_r  <= (count_r == '0);
      out_held_r   <= held_ext[HELD_W-1:0];
      out_status_r <= status_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.median_doubled = out_med_r;
  assign out_ch.empty_res      = out_empty_r;
  assign out_ch.held_count     = out_held_r;
  assign out_ch.status         = out_status_r;

endmodule

/* tb/running_median_insert_delete_tb.sv */
// Testbench for the running median block: stimulus queue, sorted-store predictor and checker.
`timescale 1ns / 100ps

module running_median_insert_delete_tb;
  import rmid_pkg::*;

  localparam int CAPACITY   = 1024;
  localparam int VALUE_BITS = 32;

  // A cycle budget with nothing moving on either channel that no correct run comes near.
  localparam int STALL_LIMIT = 1000;
  // Cycles left to run once the last result is in, to catch any stray result.
  localparam int TAIL_CYCLES = 8;
  // Window of cycles in which neither side idles.
  localparam int QUIET_FROM  = 500;
  localparam int QUIET_TO    = 1300;

  localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // One pending item. When wait_drain is set the sender holds the item back until every
  // expected result has been received.
  typedef struct packed {
    logic                         mode;
    logic signed [VALUE_BITS-1:0] value;
    logic                         wait_drain;
  } median_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS:0] median_doubled;
    logic                       empty_res;
    logic [HELD_W-1:0]          held_count;
    logic [STATUS_W-1:0]        status;
  } median_res_t;

  logic clk;
  logic rst_n;

  rmid_in_if  #(.VALUE_BITS(VALUE_BITS)) in_ch ();
  rmid_out_if #(.VALUE_BITS(VALUE_BITS)) out_ch ();

  running_median_insert_delete #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Items still to be offered, and the medians that accepted items are expected to produce.
  median_item_t pending_items[$];
  median_res_t  expected_medians[$];

  // The generator keeps its own unordered list of held values, so that most removals can
  // name a value that is really in the store when the item reaches the block.
  logic signed [VALUE_BITS-1:0] gen_held[$];

  // Predictor state: the store kept in ascending order, and its occupancy.
  logic signed [VALUE_BITS-1:0] sorted_model [CAPACITY];
  int unsigned                  model_count;

  int unsigned cycle_no;
  int unsigned stall_cycles;
  logic        watchdog_tripped;
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned adds_sent;
  int unsigned results_checked;
  int unsigned not_found_seen;
  int unsigned full_drops_seen;
  int unsigned peak_count;
  median_res_t monitor_want;
  median_res_t monitor_got;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Pick a value: small values give many duplicates and equal neighbours, the extremes
  // exercise the widest sums, and full-width random values move every bit.
  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) begin
      return $signed($urandom_range(16)) - 8;
    end else if (sel < 50) begin
      case ($urandom_range(5))
        0: return VAL_MAX;
        1: return VAL_MIN;
        2: return VAL_MAX - 1;
        3: return VAL_MIN + 1;
        4: return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic int find_held(input logic signed [VALUE_BITS-1:0] v);
    foreach (gen_held[i]) begin
      if (gen_held[i] == v) return i;
    end
    return -1;
  endfunction

  task automatic queue_item(input logic mode, input logic signed [VALUE_BITS-1:0] v,
                            input logic wait_drain = 1'b0);
    int idx;
    pending_items.insert(pending_items.size(),
                         median_item_t'{mode: mode, value: v, wait_drain: wait_drain});
    if (mode == MODE_ADD) begin
      if (gen_held.size() < CAPACITY) gen_held.insert(gen_held.size(), v);
    end else begin
      idx = find_held(v);
      if (idx >= 0) gen_held.delete(idx);
    end
  endtask

  // A run of random items. Most removals name a held value; the rest name any value, which
  // is usually absent and so exercises the not-found path.
  task automatic queue_random(input int n, input int add_pct);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < add_pct) begin
        queue_item(MODE_ADD, pick_value());
      end else if (gen_held.size() != 0 && $urandom_range(99) < 85) begin
        queue_item(MODE_REMOVE, gen_held[$urandom_range(gen_held.size() - 1)]);
      end else begin
        queue_item(MODE_REMOVE, pick_value());
      end
    end
  endtask

  task automatic build_stimulus();
    // Directed part: the empty store, the extremes of the value range, duplicates and
    // absent values, then two patterns that move every bit of the value both ways.
    queue_item(MODE_REMOVE, 5);
    queue_item(MODE_ADD,    VAL_MAX);
    queue_item(MODE_ADD,    VAL_MIN);
    queue_item(MODE_ADD,    VAL_MAX);
    queue_item(MODE_REMOVE, VAL_MIN);
    queue_item(MODE_REMOVE, VAL_MAX);
    queue_item(MODE_REMOVE, VAL_MAX);
    queue_item(MODE_REMOVE, VAL_MAX);
    queue_item(MODE_ADD,    VAL_MIN);
    queue_item(MODE_ADD,    VAL_MIN);
    queue_item(MODE_ADD,    3);
    queue_item(MODE_ADD,    3);
    queue_item(MODE_ADD,    -3);
    queue_item(MODE_REMOVE, 3);
    queue_item(MODE_REMOVE, 7);
    queue_item(MODE_REMOVE, VAL_MIN);
    queue_item(MODE_REMOVE, VAL_MIN);
    queue_item(MODE_REMOVE, 3);
    queue_item(MODE_REMOVE, -3);
    queue_item(MODE_ADD,    32'sh5555_5555);
    queue_item(MODE_ADD,    32'shAAAA_AAAA);
    queue_item(MODE_REMOVE, 32'sh5555_5555);
    queue_item(MODE_REMOVE, 32'shAAAA_AAAA);

    // Mixed traffic that grows the store slowly, after a full drain.
    queue_item(MODE_ADD, pick_value(), 1'b1);
    queue_random(420, 62);

    // Let the store shrink again with removal-heavy traffic, after another full drain.
    queue_item(MODE_REMOVE, pick_value(), 1'b1);
    queue_random(305, 30);
  endtask

  // Apply one accepted item to the sorted store and return the result it should produce.
  // An add goes after any equal values already held; a removal takes out the first match.
  task automatic predict_median(input logic mode, input logic signed [VALUE_BITS-1:0] v,
                                output median_res_t r);
    int unsigned                pos;
    int unsigned                lo;
    int unsigned                hi;
    logic [STATUS_W-1:0]        st;
    logic signed [VALUE_BITS:0] a;
    logic signed [VALUE_BITS:0] b;
    st = ST_APPLIED;
    if (mode == MODE_ADD) begin
      if (model_count >= CAPACITY) begin
        st = ST_FULL;
      end else begin
        pos = model_count;
        while (pos > 0 && sorted_model[pos-1] > v) begin
          sorted_model[pos] = sorted_model[pos-1];
          pos--;
        end
        sorted_model[pos] = v;
        model_count++;
      end
    end else begin
      pos = 0;
      while (pos < model_count && sorted_model[pos] != v) pos++;
      if (pos >= model_count) begin
        st = ST_NOT_FOUND;
      end else begin
        while (pos + 1 < model_count) begin
          sorted_model[pos] = sorted_model[pos+1];
          pos++;
        end
        model_count--;
      end
    end

    r.median_doubled = '0;
    if (model_count != 0) begin
      hi = model_count / 2;
      lo = model_count[0] ? hi : hi - 1;
      a  = sorted_model[lo];
      b  = sorted_model[hi];
      r.median_doubled = a + b;
    end
    r.empty_res  = (model_count == 0);
    r.held_count = model_count[HELD_W-1:0];
    r.status     = st;

    if (st == ST_NOT_FOUND) not_found_seen++;
    if (st == ST_FULL) full_drops_seen++;
    if (model_count > peak_count) peak_count = model_count;
  endtask

  function automatic logic quiet_window();
    return cycle_no >= QUIET_FROM && cycle_no < QUIET_TO;
  endfunction

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
  end

  // Driver. The expectation for an item is worked out at the edge that accepts it, before
  // the next item is chosen, so a held-back item sees that result still outstanding.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_median(in_ch.mode, in_ch.value, monitor_want);
        expected_medians.insert(expected_medians.size(), monitor_want);
        items_sent++;
        if (in_ch.mode == MODE_ADD) adds_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 &&
            (quiet_window() || $urandom_range(99) >= 14) &&
            (!pending_items[0].wait_drain || expected_medians.size() == 0)) begin
          in_ch.valid <= 1'b1;
          in_ch.mode  <= pending_items[0].mode;
          in_ch.value <= pending_items[0].value;
          void'(pending_items.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        monitor_got = '{median_doubled: out_ch.median_doubled, empty_res: out_ch.empty_res,
                        held_count: out_ch.held_count, status: out_ch.status};
        if (expected_medians.size() == 0) begin
          $display("%t unexpected result: median2=%0d empty=%0b held=%0d status=%0d",
                   $time, monitor_got.median_doubled, monitor_got.empty_res,
                   monitor_got.held_count, monitor_got.status);
          error_count++;
        end else begin
          monitor_want = expected_medians.pop_front();
          results_checked++;
          if (monitor_got.median_doubled !== monitor_want.median_doubled ||
              monitor_got.empty_res !== monitor_want.empty_res ||
              monitor_got.held_count !== monitor_want.held_count ||
              monitor_got.status !== monitor_want.status) begin
            $display("%t result %0d: expected median2=%0d empty=%0b held=%0d status=%0d",
                     $time, results_checked, monitor_want.median_doubled,
                     monitor_want.empty_res, monitor_want.held_count, monitor_want.status);
            $display("%t result %0d: actual   median2=%0d empty=%0b held=%0d status=%0d",
                     $time, results_checked, monitor_got.median_doubled,
                     monitor_got.empty_res, monitor_got.held_count, monitor_got.status);
            error_count++;
          end
        end
      end
      out_ch.ready <= quiet_window() || $urandom_range(99) >= 14;
    end
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT - 1) watchdog_tripped <= 1'b1;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_ADD;
    in_ch.value      = '0;
    out_ch.ready     = 1'b0;
    cycle_no         = 0;
    stall_cycles     = 0;
    watchdog_tripped = 1'b0;
    error_count      = 0;
    items_sent       = 0;
    adds_sent        = 0;
    results_checked  = 0;
    not_found_seen   = 0;
    full_drops_seen  = 0;
    peak_count       = 0;
    model_count      = 0;
    foreach (sorted_model[i]) sorted_model[i] = '0;
    build_stimulus();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (!watchdog_tripped &&
           (pending_items.size() != 0 || in_ch.valid || expected_medians.size() != 0))
      @(posedge clk);
    if (!watchdog_tripped) repeat (TAIL_CYCLES) @(posedge clk);

    if (watchdog_tripped) begin
      $display("%t timeout: nothing moved for %0d cycles", $time, STALL_LIMIT);
      error_count++;
    end
    if (expected_medians.size() != 0) begin
      $display("%t %0d expected results never arrived", $time, expected_medians.size());
      error_count++;
    end

    $display("Run covered %0d items (%0d adds, %0d removals) and checked %0d results.",
             items_sent, adds_sent, items_sent - adds_sent, results_checked);
    $display("Peak occupancy %0d of %0d; %0d removals of absent values; %0d adds dropped.",
             peak_count, CAPACITY, not_found_seen, full_drops_seen);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
